/* design/rvdec_pkg.sv */
// shared constants, types and helpers for the riscv instruction decoder
package rvdec_pkg;

   localparam int WARP_COUNT = 8;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-3:0] CSR_RV64_MODE = 1'd0;

   localparam logic [6:0] OPC_L      = 7'h03;
   localparam logic [6:0] OPC_FL     = 7'h07;
   localparam logic [6:0] OPC_EXT1   = 7'h0b;
   localparam logic [6:0] OPC_FENCE  = 7'h0f;
   localparam logic [6:0] OPC_I      = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_I_W    = 7'h1b;
   localparam logic [6:0] OPC_S      = 7'h23;
   localparam logic [6:0] OPC_FS     = 7'h27;
   localparam logic [6:0] OPC_EXT2   = 7'h2b;
   localparam logic [6:0] OPC_AMO    = 7'h2f;
   localparam logic [6:0] OPC_R      = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_R_W    = 7'h3b;
   localparam logic [6:0] OPC_FMADD  = 7'h43;
   localparam logic [6:0] OPC_FMSUB  = 7'h47;
   localparam logic [6:0] OPC_FNMSUB = 7'h4b;
   localparam logic [6:0] OPC_FNMADD = 7'h4f;
   localparam logic [6:0] OPC_FCI    = 7'h53;
   localparam logic [6:0] OPC_B      = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_SYS    = 7'h73;

   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_INT  = 2'd1;
   localparam logic [1:0] CLS_FLT  = 2'd2;

   localparam logic [2:0] FMT_R   = 3'd0;
   localparam logic [2:0] FMT_I   = 3'd1;
   localparam logic [2:0] FMT_S   = 3'd2;
   localparam logic [2:0] FMT_B   = 3'd3;
   localparam logic [2:0] FMT_U   = 3'd4;
   localparam logic [2:0] FMT_J   = 3'd5;
   localparam logic [2:0] FMT_R4  = 3'd6;
   localparam logic [2:0] FMT_BAD = 3'd7;

   // float compute funct7 groups
   localparam logic [6:0] F7_SGNJ_S  = 7'h20;
   localparam logic [6:0] F7_SGNJ_D  = 7'h21;
   localparam logic [6:0] F7_SQRT_S  = 7'h2c;
   localparam logic [6:0] F7_SQRT_D  = 7'h2d;
   localparam logic [6:0] F7_CMP_S   = 7'h50;
   localparam logic [6:0] F7_CMP_D   = 7'h51;
   localparam logic [6:0] F7_CVTI_S  = 7'h60;
   localparam logic [6:0] F7_CVTI_D  = 7'h61;
   localparam logic [6:0] F7_CVTF_S  = 7'h68;
   localparam logic [6:0] F7_CVTF_D  = 7'h69;
   localparam logic [6:0] F7_MVXF_S  = 7'h70;
   localparam logic [6:0] F7_MVXF_D  = 7'h71;
   localparam logic [6:0] F7_MVFX_S  = 7'h78;
   localparam logic [6:0] F7_MVFX_D  = 7'h79;

   typedef struct packed {
      logic [2:0]  format_code;
      logic [6:0]  dest_register;
      logic [6:0]  source_one;
      logic [6:0]  source_two;
      logic [6:0]  source_three;
      logic [31:0] immediate_value;
      logic        has_immediate;
      logic [6:0]  major_opcode;
      logic [1:0]  function_two;
      logic [2:0]  function_three;
      logic [6:0]  function_seven;
      logic [2:0]  target_warp;
   } rvdec_result_type;

   function automatic logic [6:0] reg_code(input logic [1:0] cls, input logic [4:0] idx);
      return {cls, idx};
   endfunction

endpackage

/* design/riscv_instruction_decoder_top.sv */
// RISC-V instruction decoder top level: request register, decode logic, result register.
// A request is taken while the input register is empty or hands its request on; it is held in
// the input register, decoded by the single combinational pass and lands in the result register,
// which offers it until the result side takes it. Throughput is
// one instruction per clock, set by the two register stages, which both advance while the
// result side takes. The rv64_mode register (byte address 0, reset 1) should only be
// written while no request is in flight.
module riscv_instruction_decoder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // instruction [31:0], warp_number [34:32], zero fill [39:35]
   input  logic [rvdec_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // format_code [2:0], dest_register [9:3], source_one [16:10], source_two [23:17],
   // source_three [30:24], immediate_value [62:31], has_immediate [63],
   // major_opcode [70:64], function_two [72:71], function_three [75:73],
   // function_seven [82:76], target_warp [85:83], zero fill [87:86]
   output logic [rvdec_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rvdec_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import rvdec_pkg::*;

   logic             rv64_mode_ff, rv64_mode_in;
   logic             req_valid_ff, req_valid_in;
   logic [31:0]      req_instr_ff, req_instr_in;
   logic [2:0]       req_warp_ff, req_warp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rvdec_result_type rsp_data_ff, rsp_data_in;
   rvdec_result_type decoded;
   logic             req_fire;
   logic             load_rsp;
   logic             csr_write;
   logic             csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == CSR_RV64_MODE;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit;
   assign csr_prdata = csr_hit ? {31'd0, rv64_mode_ff} : 32'd0;

   assign load_rsp   = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | load_rsp;
   assign req_fire   = req_tvalid & req_tready;

   rvdec_decode u_decode (
      .instruction (req_instr_ff),
      .warp_number (req_warp_ff),
      .rv64_mode   (rv64_mode_ff),
      .result      (decoded)
   );

   always_comb begin
      rv64_mode_in = csr_write ? csr_pwdata[0] : rv64_mode_ff;
      req_valid_in = req_fire ? 1'b1 : (load_rsp ? 1'b0 : req_valid_ff);
      req_instr_in = req_fire ? req_tdata[31:0] : req_instr_ff;
      req_warp_in  = req_fire ? req_tdata[34:32] : req_warp_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = load_rsp ? decoded : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv64_mode_ff <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rv64_mode_ff <= rv64_mode_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_instr_ff <= req_instr_in;
      req_warp_ff  <= req_warp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'd0,
                        rsp_data_ff.target_warp,
                        rsp_data_ff.function_seven,
                        rsp_data_ff.function_three,
                        rsp_data_ff.function_two,
                        rsp_data_ff.major_opcode,
                        rsp_data_ff.has_immediate,
                        rsp_data_ff.immediate_value,
                        rsp_data_ff.source_three,
                        rsp_data_ff.source_two,
                        rsp_data_ff.source_one,
                        rsp_data_ff.dest_register,
                        rsp_data_ff.format_code};

endmodule

/* design/rvdec_decode.sv */
// combinational decode of one instruction word into formats, operands and immediate
module rvdec_decode (
   input  logic [31:0]                instruction,
   input  logic [2:0]                 warp_number,
   input  logic                       rv64_mode,
   output rvdec_pkg::rvdec_result_type result
);
   import rvdec_pkg::*;

   logic [6:0]  op;
   logic [4:0]  rd, rs1, rs2, rs3;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [2:0]  fmt;
   logic [6:0]  d, s1, s2, s3;
   logic [31:0] imm;
   logic        hi;
   logic [1:0]  o2;
   logic [2:0]  o3;
   logic [6:0]  o7;
   logic        warp_bad;

   assign op  = instruction[6:0];
   assign rd  = instruction[11:7];
   assign rs1 = instruction[19:15];
   assign rs2 = instruction[24:20];
   assign rs3 = instruction[31:27];
   assign f3  = instruction[14:12];
   assign f7  = instruction[31:25];
   assign warp_bad = 32'(warp_number) >= WARP_COUNT;

   always_comb begin
      fmt = FMT_BAD;
      d   = '0;
      s1  = '0;
      s2  = '0;
      s3  = '0;
      imm = '0;
      hi  = 1'b0;
      o2  = '0;
      o7  = '0;
      case (op)
         OPC_R, OPC_AMO, OPC_R_W: begin
            fmt = FMT_R;
            d   = reg_code(CLS_INT, rd);
            s1  = reg_code(CLS_INT, rs1);
            s2  = reg_code(CLS_INT, rs2);
         end
         OPC_FCI: begin
            fmt = FMT_R;
            case (f7)
               F7_SGNJ_S, F7_SGNJ_D, F7_SQRT_S, F7_SQRT_D: begin
                  d  = reg_code(CLS_FLT, rd);
                  s1 = reg_code(CLS_FLT, rs1);
               end
               F7_CMP_S, F7_CMP_D: begin
                  d  = reg_code(CLS_INT, rd);
                  s1 = reg_code(CLS_FLT, rs1);
                  s2 = reg_code(CLS_FLT, rs2);
               end
               F7_CVTI_S, F7_CVTI_D: begin
                  d  = reg_code(CLS_INT, rd);
                  s1 = reg_code(CLS_FLT, rs1);
                  s2 = reg_code(CLS_NONE, rs2);
               end
               F7_CVTF_S, F7_CVTF_D: begin
                  d  = reg_code(CLS_FLT, rd);
                  s1 = reg_code(CLS_INT, rs1);
                  s2 = reg_code(CLS_NONE, rs2);
               end
               F7_MVXF_S, F7_MVXF_D: begin
                  d  = reg_code(CLS_INT, rd);
                  s1 = reg_code(CLS_FLT, rs1);
               end
               F7_MVFX_S, F7_MVFX_D: begin
                  d  = reg_code(CLS_FLT, rd);
                  s1 = reg_code(CLS_INT, rs1);
               end
               default: begin
                  d  = reg_code(CLS_FLT, rd);
                  s1 = reg_code(CLS_FLT, rs1);
                  s2 = reg_code(CLS_FLT, rs2);
               end
            endcase
         end
         OPC_EXT1: begin
            if (f7 == 7'd0 && f3 < 3'd6) begin
               fmt = FMT_R;
               s1  = reg_code(CLS_INT, rs1);
               if (f3 == 3'd1 || f3 == 3'd4) begin
                  s2 = reg_code(CLS_INT, rs2);
               end else if (f3 == 3'd5) begin
                  d  = reg_code(CLS_NONE, rd);
                  s2 = reg_code(CLS_INT, rs2);
               end else if (f3 == 3'd2) begin
                  d  = reg_code(CLS_INT, rd);
                  s2 = reg_code(CLS_NONE, rs2);
               end
            end
         end
         OPC_I, OPC_I_W, OPC_JALR: begin
            fmt = FMT_I;
            d   = reg_code(CLS_INT, rd);
            s1  = reg_code(CLS_INT, rs1);
            hi  = 1'b1;
            if (f3 == 3'd1 || f3 == 3'd5) begin
               imm = {26'd0, rv64_mode & (op == OPC_I) & f7[0], rs2};
               o7  = f7;
            end else begin
               imm = {{20{instruction[31]}}, instruction[31:20]};
            end
         end
         OPC_L, OPC_FL: begin
            if (op == OPC_L || f3 == 3'd2 || f3 == 3'd3) begin
               fmt = FMT_I;
               hi  = 1'b1;
               d   = reg_code((op == OPC_FL) ? CLS_FLT : CLS_INT, rd);
               s1  = reg_code(CLS_INT, rs1);
               imm = {{20{instruction[31]}}, instruction[31:20]};
            end
         end
         OPC_FENCE: begin
            fmt = FMT_I;
            hi  = 1'b1;
            imm = {20'd0, instruction[31:20]};
         end
         OPC_SYS: begin
            fmt = FMT_I;
            hi  = 1'b1;
            imm = {20'd0, instruction[31:20]};
            if (f3 != 3'd0) begin
               d  = reg_code(CLS_INT, rd);
               s1 = reg_code((f3 < 3'd5) ? CLS_INT : CLS_NONE, rs1);
            end
         end
         OPC_S, OPC_FS: begin
            if (op == OPC_S || f3 == 3'd2 || f3 == 3'd3) begin
               fmt = FMT_S;
               hi  = 1'b1;
               s1  = reg_code(CLS_INT, rs1);
               s2  = reg_code((op == OPC_FS) ? CLS_FLT : CLS_INT, rs2);
               imm = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
            end
         end
         OPC_B: begin
            fmt = FMT_B;
            hi  = 1'b1;
            s1  = reg_code(CLS_INT, rs1);
            s2  = reg_code(CLS_INT, rs2);
            imm = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                   instruction[11:8], 1'b0};
         end
         OPC_LUI, OPC_AUIPC: begin
            fmt = FMT_U;
            hi  = 1'b1;
            d   = reg_code(CLS_INT, rd);
            imm = {instruction[31:12], 12'd0};
         end
         OPC_JAL: begin
            fmt = FMT_J;
            hi  = 1'b1;
            d   = reg_code(CLS_INT, rd);
            imm = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                   instruction[30:21], 1'b0};
         end
         OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD, OPC_EXT2: begin
            fmt = FMT_R4;
            d   = reg_code(CLS_FLT, rd);
            s1  = reg_code(CLS_FLT, rs1);
            s2  = reg_code(CLS_FLT, rs2);
            s3  = reg_code(CLS_FLT, rs3);
            o2  = instruction[26:25];
         end
         default: begin
            fmt = FMT_BAD;
         end
      endcase

      if (fmt == FMT_R) begin
         o7 = f7;
      end
      o3 = (fmt != FMT_U && fmt != FMT_J) ? f3 : 3'd0;

      if (fmt == FMT_BAD || warp_bad) begin
         fmt = FMT_BAD;
         d   = '0;
         s1  = '0;
         s2  = '0;
         s3  = '0;
         imm = '0;
         hi  = 1'b0;
         o2  = '0;
         o3  = '0;
         o7  = '0;
      end

      result.format_code     = fmt;
      result.dest_register   = d;
      result.source_one      = s1;
      result.source_two      = s2;
      result.source_three    = s3;
      result.immediate_value = imm;
      result.has_immediate   = hi;
      result.major_opcode    = op;
      result.function_two    = o2;
      result.function_three  = o3;
      result.function_seven  = o7;
      result.target_warp     = warp_number;
   end

endmodule

/* bench/tb_top.sv */
// testbench for riscv_instruction_decoder_top: directed and random decodes checked against a predictor
module tb_top;
   import rvdec_pkg::*;

   localparam logic [6:0] OPC_VECTOR = 7'h57;

   localparam logic [2:0] F3_SLL        = 3'd1;
   localparam logic [2:0] F3_SRL        = 3'd5;
   localparam logic [2:0] F3_WORD       = 3'd2;
   localparam logic [2:0] F3_DOUBLE     = 3'd3;
   localparam logic [2:0] F3_VECTOR_E8  = 3'd0;
   localparam logic [2:0] F3_VECTOR_E64 = 3'd7;

   localparam logic [2:0] WCTL_TMC    = 3'd0;
   localparam logic [2:0] WCTL_WSPAWN = 3'd1;
   localparam logic [2:0] WCTL_SPLIT  = 3'd2;
   localparam logic [2:0] WCTL_BAR    = 3'd4;
   localparam logic [2:0] WCTL_PRED   = 3'd5;
   localparam logic [2:0] WCTL_RSVD6  = 3'd6;
   localparam logic [2:0] WCTL_RSVD7  = 3'd7;

   localparam logic [2:0] SYS_F3_PRIV   = 3'd0;
   localparam logic [2:0] SYS_F3_CSRRWI = 3'd5;

   localparam logic [CSR_ADDR_W-1:0] RV64_MODE_ADDR = {CSR_RV64_MODE, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   rvdec_result_type expected_decodes[$];
   logic             wide_shifts = 1'b1;
   bit               pressure_on = 1'b1;
   int               mismatch_count = 0;
   int               decodes_checked = 0;
   int               tready_hold = 0;

   riscv_instruction_decoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rvdec_result_type decode_instruction(input logic [31:0] word,
                                                           input logic [2:0] warp,
                                                           input logic wide);
      rvdec_result_type r;
      logic [6:0] op;
      logic [6:0] f7;
      logic [4:0] rd;
      logic [4:0] rs1;
      logic [4:0] rs2;
      logic [4:0] rs3;
      logic [2:0] f3;
      op  = word[6:0];
      rd  = word[11:7];
      f3  = word[14:12];
      rs1 = word[19:15];
      rs2 = word[24:20];
      rs3 = word[31:27];
      f7  = word[31:25];
      r = '0;
      r.format_code = FMT_BAD;
      case (op)
         OPC_R, OPC_AMO, OPC_R_W: begin
            r.format_code   = FMT_R;
            r.dest_register = {CLS_INT, rd};
            r.source_one    = {CLS_INT, rs1};
            r.source_two    = {CLS_INT, rs2};
         end
         OPC_FCI: begin
            r.format_code = FMT_R;
            case (f7)
               F7_SGNJ_S, F7_SGNJ_D, F7_SQRT_S, F7_SQRT_D: begin
                  r.dest_register = {CLS_FLT, rd};
                  r.source_one    = {CLS_FLT, rs1};
               end
               F7_CMP_S, F7_CMP_D: begin
                  r.dest_register = {CLS_INT, rd};
                  r.source_one    = {CLS_FLT, rs1};
                  r.source_two    = {CLS_FLT, rs2};
               end
               F7_CVTI_S, F7_CVTI_D: begin
                  r.dest_register = {CLS_INT, rd};
                  r.source_one    = {CLS_FLT, rs1};
                  r.source_two    = {CLS_NONE, rs2};
               end
               F7_CVTF_S, F7_CVTF_D: begin
                  r.dest_register = {CLS_FLT, rd};
                  r.source_one    = {CLS_INT, rs1};
                  r.source_two    = {CLS_NONE, rs2};
               end
               F7_MVXF_S, F7_MVXF_D: begin
                  r.dest_register = {CLS_INT, rd};
                  r.source_one    = {CLS_FLT, rs1};
               end
               F7_MVFX_S, F7_MVFX_D: begin
                  r.dest_register = {CLS_FLT, rd};
                  r.source_one    = {CLS_INT, rs1};
               end
               default: begin
                  r.dest_register = {CLS_FLT, rd};
                  r.source_one    = {CLS_FLT, rs1};
                  r.source_two    = {CLS_FLT, rs2};
               end
            endcase
         end
         OPC_EXT1: begin
            if (f7 == 7'd0 && f3 <= WCTL_PRED) begin
               r.format_code = FMT_R;
               r.source_one  = {CLS_INT, rs1};
               case (f3)
                  WCTL_WSPAWN, WCTL_BAR: r.source_two = {CLS_INT, rs2};
                  WCTL_PRED: begin
                     r.dest_register = {CLS_NONE, rd};
                     r.source_two    = {CLS_INT, rs2};
                  end
                  WCTL_SPLIT: begin
                     r.dest_register = {CLS_INT, rd};
                     r.source_two    = {CLS_NONE, rs2};
                  end
                  default: ;
               endcase
            end
         end
         OPC_I, OPC_I_W, OPC_JALR: begin
            r.format_code   = FMT_I;
            r.dest_register = {CLS_INT, rd};
            r.source_one    = {CLS_INT, rs1};
            r.has_immediate = 1'b1;
            if (f3 == F3_SLL || f3 == F3_SRL) begin
               r.immediate_value = {27'd0, rs2};
               if (wide && op == OPC_I)
                  r.immediate_value[5] = f7[0];
               r.function_seven = f7;
            end else begin
               r.immediate_value = {{20{word[31]}}, word[31:20]};
            end
         end
         OPC_L, OPC_FL: begin
            if (op == OPC_L || f3 == F3_WORD || f3 == F3_DOUBLE) begin
               r.format_code     = FMT_I;
               r.has_immediate   = 1'b1;
               r.dest_register   = {(op == OPC_FL) ? CLS_FLT : CLS_INT, rd};
               r.source_one      = {CLS_INT, rs1};
               r.immediate_value = {{20{word[31]}}, word[31:20]};
            end
         end
         OPC_FENCE, OPC_SYS: begin
            r.format_code     = FMT_I;
            r.has_immediate   = 1'b1;
            r.immediate_value = {20'd0, word[31:20]};
            if (op == OPC_SYS && f3 != SYS_F3_PRIV) begin
               r.dest_register = {CLS_INT, rd};
               r.source_one    = {(f3 < SYS_F3_CSRRWI) ? CLS_INT : CLS_NONE, rs1};
            end
         end
         OPC_S, OPC_FS: begin
            if (op == OPC_S || f3 == F3_WORD || f3 == F3_DOUBLE) begin
               r.format_code     = FMT_S;
               r.has_immediate   = 1'b1;
               r.source_one      = {CLS_INT, rs1};
               r.source_two      = {(op == OPC_FS) ? CLS_FLT : CLS_INT, rs2};
               r.immediate_value = {{20{word[31]}}, word[31:25], word[11:7]};
            end
         end
         OPC_B: begin
            r.format_code     = FMT_B;
            r.has_immediate   = 1'b1;
            r.source_one      = {CLS_INT, rs1};
            r.source_two      = {CLS_INT, rs2};
            r.immediate_value = {{19{word[31]}}, word[31], word[7], word[30:25],
                                 word[11:8], 1'b0};
         end
         OPC_LUI, OPC_AUIPC: begin
            r.format_code     = FMT_U;
            r.has_immediate   = 1'b1;
            r.dest_register   = {CLS_INT, rd};
            r.immediate_value = {word[31:12], 12'd0};
         end
         OPC_JAL: begin
            r.format_code     = FMT_J;
            r.has_immediate   = 1'b1;
            r.dest_register   = {CLS_INT, rd};
            r.immediate_value = {{11{word[31]}}, word[31], word[19:12], word[20],
                                 word[30:21], 1'b0};
         end
         OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD, OPC_EXT2: begin
            r.format_code   = FMT_R4;
            r.dest_register = {CLS_FLT, rd};
            r.source_one    = {CLS_FLT, rs1};
            r.source_two    = {CLS_FLT, rs2};
            r.source_three  = {CLS_FLT, rs3};
            r.function_two  = word[26:25];
         end
         default: ;
      endcase
      if (r.format_code == FMT_R)
         r.function_seven = f7;
      if (r.format_code != FMT_U && r.format_code != FMT_J)
         r.function_three = f3;
      if (r.format_code == FMT_BAD || int'(warp) >= WARP_COUNT) begin
         r = '0;
         r.format_code = FMT_BAD;
      end
      r.major_opcode = op;
      r.target_warp  = warp;
      return r;
   endfunction

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [6:0] opcode_at(input int k);
      case (k)
         0:       return OPC_L;
         1:       return OPC_FL;
         2:       return OPC_EXT1;
         3:       return OPC_FENCE;
         4:       return OPC_I;
         5:       return OPC_AUIPC;
         6:       return OPC_I_W;
         7:       return OPC_S;
         8:       return OPC_FS;
         9:       return OPC_EXT2;
         10:      return OPC_AMO;
         11:      return OPC_R;
         12:      return OPC_LUI;
         13:      return OPC_R_W;
         14:      return OPC_FMADD;
         15:      return OPC_FMSUB;
         16:      return OPC_FNMSUB;
         17:      return OPC_FNMADD;
         18:      return OPC_FCI;
         19:      return OPC_B;
         20:      return OPC_JALR;
         21:      return OPC_JAL;
         default: return OPC_SYS;
      endcase
   endfunction

   function automatic logic [31:0] random_instruction(input bit shift_heavy);
      logic [6:0] op;
      logic [6:0] f7;
      logic [2:0] f3;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12)
         return $urandom();
      op = opcode_at($urandom_range(0, 22));
      f3 = 3'($urandom_range(0, 7));
      f7 = 7'($urandom_range(0, 127));
      if (shift_heavy && roll < 55) begin
         case ($urandom_range(0, 3))
            0:       op = OPC_I_W;
            1:       op = OPC_JALR;
            default: op = OPC_I;
         endcase
         f3 = $urandom_range(0, 1) ? F3_SLL : F3_SRL;
      end
      case (op)
         OPC_FCI: begin
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 6))
                  0:       f7 = F7_SGNJ_S;
                  1:       f7 = F7_SQRT_S;
                  2:       f7 = F7_CMP_S;
                  3:       f7 = F7_CVTI_S;
                  4:       f7 = F7_CVTF_S;
                  5:       f7 = F7_MVXF_S;
                  default: f7 = F7_MVFX_S;
               endcase
               f7[0] = 1'($urandom_range(0, 1));
            end
         end
         OPC_EXT1: if ($urandom_range(0, 4) != 0) f7 = '0;
         OPC_FL, OPC_FS: begin
            if ($urandom_range(0, 4) != 0)
               f3 = $urandom_range(0, 1) ? F3_DOUBLE : F3_WORD;
         end
         default: ;
      endcase
      return {f7, 5'($urandom()), 5'($urandom()), f3, 5'($urandom()), op};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("decode %0d %s got 0x%0h expected 0x%0h",
                                   decodes_checked, name, got, want));
   endtask

   // predict on acceptance, then compare each result with the oldest prediction
   always @(posedge clock) begin : track_decodes
      rvdec_result_type want;
      if (!reset && req_tvalid && req_tready)
         expected_decodes.insert(expected_decodes.size(),
                                 decode_instruction(req_tdata[31:0], req_tdata[34:32],
                                                    wide_shifts));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch($sformatf("unexpected result 0x%0h", rsp_tdata));
         end else begin
            want = expected_decodes.pop_front();
            check_field("format_code", 32'(rsp_tdata[2:0]), 32'(want.format_code));
            check_field("dest_register", 32'(rsp_tdata[9:3]), 32'(want.dest_register));
            check_field("source_one", 32'(rsp_tdata[16:10]), 32'(want.source_one));
            check_field("source_two", 32'(rsp_tdata[23:17]), 32'(want.source_two));
            check_field("source_three", 32'(rsp_tdata[30:24]), 32'(want.source_three));
            check_field("immediate_value", rsp_tdata[62:31], want.immediate_value);
            check_field("has_immediate", 32'(rsp_tdata[63]), 32'(want.has_immediate));
            check_field("major_opcode", 32'(rsp_tdata[70:64]), 32'(want.major_opcode));
            check_field("function_two", 32'(rsp_tdata[72:71]), 32'(want.function_two));
            check_field("function_three", 32'(rsp_tdata[75:73]),
                        32'(want.function_three));
            check_field("function_seven", 32'(rsp_tdata[82:76]),
                        32'(want.function_seven));
            check_field("target_warp", 32'(rsp_tdata[85:83]), 32'(want.target_warp));
         end
         decodes_checked++;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (!pressure_on) begin
         rsp_tready <= 1'b1;
         tready_hold = 0;
      end else if (tready_hold > 0) begin
         tready_hold = tready_hold - 1;
      end else if ($urandom_range(0, 9) < 6) begin
         rsp_tready <= 1'b1;
         tready_hold = $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b0;
         tready_hold = random_gap();
      end
   end

   task automatic send_instruction(input logic [31:0] word, input logic [2:0] warp);
      int gap;
      gap = pressure_on ? random_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {5'd0, warp, word};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_op(input logic [6:0] op, input logic [2:0] f3, input logic [6:0] f7);
      send_instruction({f7, 5'($urandom()), 5'($urandom()), f3, 5'($urandom()), op},
                       3'($urandom_range(0, 7)));
   endtask

   task automatic wait_for_drain(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_decodes.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic apb_transfer(input logic is_write, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= RV64_MODE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_rv64_mode(input logic mode);
      logic [31:0] readback;
      wait_for_drain(4);
      apb_transfer(1'b1, {31'd0, mode}, readback);
      wide_shifts = mode;
      apb_transfer(1'b0, 32'd0, readback);
      check_field("rv64_mode readback", readback, {31'd0, mode});
   endtask

   task automatic run_random_decodes(input int count, input bit shift_heavy);
      repeat (count)
         send_instruction(random_instruction(shift_heavy), 3'($urandom_range(0, 7)));
   endtask

   // every opcode at least once plus the illegal and odd-class corners, in reset mode
   task automatic test_directed_decodes();
      send_instruction(32'h0000_0000, 3'd0);
      send_instruction(32'hffff_ffff, 3'd7);
      send_op(OPC_L, 3'($urandom()), 7'($urandom()));
      send_op(OPC_AUIPC, 3'($urandom()), 7'($urandom()));
      send_op(OPC_S, 3'($urandom()), 7'($urandom()));
      send_op(OPC_EXT2, 3'($urandom()), 7'($urandom()));
      send_op(OPC_AMO, 3'($urandom()), 7'($urandom()));
      send_op(OPC_R, 3'($urandom()), 7'($urandom()));
      send_op(OPC_LUI, 3'($urandom()), 7'($urandom()));
      send_op(OPC_R_W, 3'($urandom()), 7'($urandom()));
      send_op(OPC_FMADD, 3'($urandom()), 7'($urandom()));
      send_op(OPC_FMSUB, 3'($urandom()), 7'($urandom()));
      send_op(OPC_FNMSUB, 3'($urandom()), 7'($urandom()));
      send_op(OPC_FNMADD, 3'($urandom()), 7'($urandom()));
      send_op(OPC_B, 3'($urandom()), 7'($urandom()));
      send_op(OPC_JAL, 3'($urandom()), 7'($urandom()));
      send_op(OPC_VECTOR, 3'($urandom()), 7'($urandom()));
      send_op(OPC_FL, F3_WORD, 7'($urandom()));
      send_op(OPC_FL, F3_VECTOR_E8, 7'($urandom()));
      send_op(OPC_FS, F3_DOUBLE, 7'($urandom()));
      send_op(OPC_FS, F3_VECTOR_E64, 7'($urandom()));
      send_op(OPC_EXT1, WCTL_TMC, 7'h40);
      send_op(OPC_EXT1, WCTL_PRED, 7'h00);
      send_op(OPC_EXT1, WCTL_SPLIT, 7'h00);
      send_op(OPC_EXT1, WCTL_RSVD6, 7'h00);
      send_op(OPC_EXT1, WCTL_RSVD7, 7'h00);
      send_op(OPC_I, F3_SLL, 7'h01);
      send_op(OPC_I_W, F3_SRL, 7'h21);
      send_op(OPC_JALR, F3_SLL, 7'h7f);
      send_op(OPC_FENCE, 3'($urandom()), 7'h7f);
      send_op(OPC_SYS, SYS_F3_PRIV, 7'($urandom()));
      send_op(OPC_SYS, SYS_F3_CSRRWI, 7'($urandom()));
      send_op(OPC_FCI, 3'($urandom()), F7_CVTI_S);
      send_op(OPC_FCI, 3'($urandom()), F7_CVTF_D);
   endtask

   task automatic test_random_decodes();
      run_random_decodes(600, 1'b0);
   endtask

   task automatic test_narrow_shifts();
      set_rv64_mode(1'b0);
      run_random_decodes(350, 1'b1);
   endtask

   task automatic test_streaming();
      pressure_on = 1'b0;
      run_random_decodes(200, 1'b0);
      pressure_on = 1'b1;
   endtask

   task automatic test_wide_shifts();
      set_rv64_mode(1'b1);
      run_random_decodes(270, 1'b1);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed_decodes();
      test_random_decodes();
      test_narrow_shifts();
      test_streaming();
      test_wide_shifts();
      wait_for_drain(8);
      if (expected_decodes.size() != 0)
         report_mismatch($sformatf("%0d decodes never came out", expected_decodes.size()));
      if (mismatch_count == 0) begin
         $display("** riscv_instruction_decoder_top: PASSED **");
      end else begin
         $display("** riscv_instruction_decoder_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout after %0d decodes", decodes_checked);
      $display("** riscv_instruction_decoder_top: FAILED **");
      $finish;
   end

endmodule
